[sv/irbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irbb_pkg
// Shared types, register map and cubic-convolution weight function for the
// image resampler.
// ----------------------------------------------------------------------------
package irbb_pkg;

    // signed tap weight, Q2.24 (bicubic) or Q0.8 (bilinear)
    typedef logic signed [26:0] weight_t;

    // request operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // configuration register indexes (paddr[4:2])
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCALE_X    = 3'd2;
    localparam logic [2:0] REG_SCALE_Y    = 3'd3;
    localparam logic [2:0] REG_METHOD     = 3'd4;
    localparam logic [2:0] REG_HAS_ALPHA  = 3'd5;

    localparam logic METHOD_BILINEAR = 1'b0;
    localparam logic METHOD_BICUBIC  = 1'b1;

    // cubic convolution weight, a = -1, f in Q0.8, result Q2.24
    function automatic weight_t cubic_weight(input logic [7:0] f, input logic [1:0] idx);
        weight_t fs;
        weight_t f2;
        weight_t f3;
        weight_t w;
        begin
            fs = $signed({19'd0, f});
            f2 = fs * fs;
            f3 = f2 * fs;
            unique case (idx)
                2'd0: w = -f3 + (f2 <<< 9) - (fs <<< 16);
                2'd1: w = f3 - (f2 <<< 9) + 27'sd16777216;
                2'd2: w = -f3 + (f2 <<< 8) + (fs <<< 16);
                2'd3: w = f3 - (f2 <<< 8);
                default: w = '0;
            endcase
            return w;
        end
    endfunction

endpackage

[sv/image_resampler_bilinear_bicubic_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_resampler_bilinear_bicubic_core
// Source pixel store plus bilinear / bicubic resampler; one tap per cycle
// through a shared weight multiply and multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
// Channel   | Signals                                    | Direction
// ----------+--------------------------------------------+----------
// request   | start, busy, op, col, row, pixel_in        | in (busy out)
// result    | done, red, green, blue, alpha              | out
// config    | psel, penable, pwrite, paddr, pwdata,      | in
//           | prdata, pready                             | out
//
// A request is taken at a rising edge with start high and busy low.
// A write request (op 0) is stored at that edge if col and row lie within the store; busy stays low, no result.
// A read request (op 1) passes through the weight state, N taps (N = 4
// bilinear, 16 bicubic), a drain of the multiply-accumulate pipeline and a
// finish state: the single-port store yields one source pixel per cycle and
// sets the pace; busy stays high through the finish state, low again with done.
// done pulses for one cycle with the pixel on red/green/blue/alpha; the
// receiver cannot stall it.
// Reset (rst_n, async, low) restores the control and configuration registers;
// the store is undefined until written and needs no clearing.
//
module image_resampler_bilinear_bicubic_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [11:0] col,
    input  logic [11:0] row,
    input  logic [31:0] pixel_in,
    // result
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WGT   = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // ---------------- configuration registers ----------------
    logic [6:0]  src_width_reg;
    logic [6:0]  src_height_reg;
    logic [21:0] scale_x_reg;
    logic [21:0] scale_y_reg;
    logic        method_reg;
    logic        has_alpha_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 7'd64;
            src_height_reg <= 7'd64;
            scale_x_reg    <= 22'd65536;
            scale_y_reg    <= 22'd65536;
            method_reg     <= irbb_pkg::METHOD_BILINEAR;
            has_alpha_reg  <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                irbb_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[6:0];
                irbb_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[6:0];
                irbb_pkg::REG_SCALE_X:    scale_x_reg    <= pwdata[21:0];
                irbb_pkg::REG_SCALE_Y:    scale_y_reg    <= pwdata[21:0];
                irbb_pkg::REG_METHOD:     method_reg     <= pwdata[0];
                irbb_pkg::REG_HAS_ALPHA:  has_alpha_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            irbb_pkg::REG_SRC_WIDTH:  prdata = {25'd0, src_width_reg};
            irbb_pkg::REG_SRC_HEIGHT: prdata = {25'd0, src_height_reg};
            irbb_pkg::REG_SCALE_X:    prdata = {10'd0, scale_x_reg};
            irbb_pkg::REG_SCALE_Y:    prdata = {10'd0, scale_y_reg};
            irbb_pkg::REG_METHOD:     prdata = {31'd0, method_reg};
            irbb_pkg::REG_HAS_ALPHA:  prdata = {31'd0, has_alpha_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    logic [2:0]  state_reg, state_next;
    logic [33:0] px_reg;
    logic [33:0] py_reg;
    logic [17:0] bx_reg;
    logic [17:0] by_reg;
    logic [CW-1:0] lastx_reg;
    logic [RW-1:0] lasty_reg;
    irbb_pkg::weight_t wx_reg [4];
    irbb_pkg::weight_t wy_reg [4];
    logic [3:0]  tap_reg;
    logic        v1_reg;
    logic        v2_reg;

    logic accept;
    logic wr_en;
    logic rd_en;
    logic last_tap;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start & ~busy;
    assign wr_en  = accept & (op == irbb_pkg::OP_WRITE)
                    & (32'(col) < 32'(MAX_WIDTH)) & (32'(row) < 32'(MAX_HEIGHT));
    assign rd_en  = (state_reg == S_RUN);
    assign last_tap = (method_reg == irbb_pkg::METHOD_BICUBIC) ? (tap_reg == 4'd15)
                                                               : (tap_reg == 4'd3);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && (op == irbb_pkg::OP_READ)) state_next = S_WGT;
            S_WGT:   state_next = S_RUN;
            S_RUN:   if (last_tap) state_next = S_DRAIN;
            S_DRAIN: if (!v1_reg && !v2_reg) state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= rd_en;
            v2_reg    <= v1_reg;
            if (state_reg == S_RUN)
                tap_reg <= tap_reg + 4'd1;
            else
                tap_reg <= '0;
        end
    end

    // source position: col * scale_x, row * scale_y (Q.16)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= 34'(col) * 34'(scale_x_reg);
            py_reg <= 34'(row) * 34'(scale_y_reg);
        end
    end

    // width / height from the size registers, clamped to 1 .. MAX_WIDTH / MAX_HEIGHT
    logic [10:0] wv;
    logic [10:0] hv;

    always_comb
    begin
        wv = {4'd0, src_width_reg};
        hv = {4'd0, src_height_reg};
        if (wv == 11'd0)
            wv = 11'd1;
        else if (32'(wv) > 32'(MAX_WIDTH))
            wv = 11'(MAX_WIDTH);
        if (hv == 11'd0)
            hv = 11'd1;
        else if (32'(hv) > 32'(MAX_HEIGHT))
            hv = 11'(MAX_HEIGHT);
    end

    // base pixel, fraction and weights
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WGT)
        begin
            bx_reg    <= px_reg[33:16];
            by_reg    <= py_reg[33:16];
            lastx_reg <= CW'(wv - 11'd1);
            lasty_reg <= RW'(hv - 11'd1);
            for (int k = 0; k < 4; k++)
            begin
                if (method_reg == irbb_pkg::METHOD_BICUBIC)
                begin
                    wx_reg[k] <= irbb_pkg::cubic_weight(px_reg[15:8], 2'(k));
                    wy_reg[k] <= irbb_pkg::cubic_weight(py_reg[15:8], 2'(k));
                end
                else
                begin
                    wx_reg[k] <= '0;
                    wy_reg[k] <= '0;
                end
            end
            if (method_reg == irbb_pkg::METHOD_BILINEAR)
            begin
                wx_reg[0] <= 27'sd256 - $signed({19'd0, px_reg[15:8]});
                wx_reg[1] <= $signed({19'd0, px_reg[15:8]});
                wy_reg[0] <= 27'sd256 - $signed({19'd0, py_reg[15:8]});
                wy_reg[1] <= $signed({19'd0, py_reg[15:8]});
            end
        end
    end

    // tap address with edge clamping
    logic [1:0]  ti;
    logic [1:0]  tj;
    logic [2:0]  offx;
    logic [2:0]  offy;
    logic signed [19:0] xs;
    logic signed [19:0] ys;
    logic [CW-1:0] cx;
    logic [RW-1:0] cy;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    always_comb
    begin
        if (method_reg == irbb_pkg::METHOD_BICUBIC)
        begin
            ti   = tap_reg[1:0];
            tj   = tap_reg[3:2];
            offx = {1'b0, ti} - 3'd1;
            offy = {1'b0, tj} - 3'd1;
        end
        else
        begin
            ti   = {1'b0, tap_reg[0]};
            tj   = {1'b0, tap_reg[1]};
            offx = {1'b0, ti};
            offy = {1'b0, tj};
        end
        xs = $signed({2'b00, bx_reg}) + $signed({{17{offx[2]}}, offx});
        ys = $signed({2'b00, by_reg}) + $signed({{17{offy[2]}}, offy});
        if (xs[19])
            cx = '0;
        else if (xs[18:0] > 19'(lastx_reg))
            cx = lastx_reg;
        else
            cx = xs[CW-1:0];
        if (ys[19])
            cy = '0;
        else if (ys[18:0] > 19'(lasty_reg))
            cy = lasty_reg;
        else
            cy = ys[RW-1:0];
        raddr = AW'(cy) * AW'(MAX_WIDTH) + AW'(cx);
        waddr = AW'(row[RW-1:0]) * AW'(MAX_WIDTH) + AW'(col[CW-1:0]);
    end

    // ---------------- source pixel store ----------------
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= pixel_in;
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    // ---------------- shared multiply-accumulate ----------------
    logic signed [53:0] wprod_reg;
    logic signed [62:0] prod_reg [4];
    logic signed [63:0] acc_reg  [4];

    always_ff @(posedge clk)
    begin
        if (rd_en)
            wprod_reg <= wx_reg[ti] * wy_reg[tj];
        for (int c = 0; c < 4; c++)
        begin
            if (v1_reg)
                prod_reg[c] <= wprod_reg * $signed({1'b0, rdata_reg[8*c +: 8]});
            if (state_reg == S_WGT)
                acc_reg[c] <= '0;
            else if (v2_reg)
                acc_reg[c] <= acc_reg[c] + {prod_reg[c][62], prod_reg[c]};
        end
    end

    // ---------------- result ----------------
    logic [7:0] chan [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (method_reg == irbb_pkg::METHOD_BICUBIC)
            begin
                if (acc_reg[c][63])
                    chan[c] = 8'd0;
                else if (|acc_reg[c][62:56])
                    chan[c] = 8'd255;
                else
                    chan[c] = acc_reg[c][55:48];
            end
            else
                chan[c] = acc_reg[c][23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= (state_reg == S_FIN);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN)
        begin
            red   <= chan[0];
            green <= chan[1];
            blue  <= chan[2];
            alpha <= has_alpha_reg ? chan[3] : 8'd0;
        end
    end

endmodule
